// File: rtl/core/opr_pkg.sv
// Package for the overwriting packet ring queue.
// Holds sizes, item structs, the command codes and the controller/datapath link types.
// No dependencies.
`timescale 1ns / 1ps

package opr_pkg;

	localparam int QUEUE_SLOTS  = 8;
	localparam int PACKET_BYTES = 32;

	localparam int SLOT_W      = $clog2(QUEUE_SLOTS);
	localparam int STORE_DEPTH = QUEUE_SLOTS * PACKET_BYTES;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int CNT_W       = $clog2(PACKET_BYTES + 1);
	localparam int SIZE_W      = 6;

	// Request command codes
	localparam logic CMD_ENQ = 1'b0;
	localparam logic CMD_DEQ = 1'b1;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data_byte;
		logic       last_byte;
	} req_item_t;

	typedef struct packed {
		logic [7:0]        out_byte;
		logic [SIZE_W-1:0] packet_size;
		logic              queue_empty;
		logic              last_out;
	} rsp_item_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} ctrl_state_t;

	// Controller to datapath
	typedef struct packed {
		logic enq_write;
		logic deq_start;
		logic issue;
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic issue_ok;
		logic last_issue;
	} dp_stat_t;

endpackage

// File: rtl/core/opr_ctrl.sv
// Controller for the overwriting packet ring queue.
// Accepts requests when idle and sequences the byte reads of a dequeue.
// Depends on opr_pkg.
`timescale 1ns / 1ps

module opr_ctrl import opr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	input  logic      req_cmd,
	output logic      req_stall,
	input  dp_stat_t  stat,
	output ctrl_cmd_t cmd
);

	ctrl_state_t state_q;
	ctrl_state_t state_next;
	logic        accept;

	assign accept = req_valid && !req_stall;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next state
	always_comb begin
		state_next = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req_cmd == CMD_DEQ) begin
					state_next = ST_RUN;
				end
			end
			ST_RUN: begin
				if (stat.issue_ok && stat.last_issue) begin
					state_next = ST_IDLE;
				end
			end
			default: state_next = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		req_stall     = 1'b1;
		cmd.enq_write = 1'b0;
		cmd.deq_start = 1'b0;
		cmd.issue     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				req_stall     = 1'b0;
				cmd.enq_write = req_valid && req_cmd == CMD_ENQ;
				cmd.deq_start = req_valid && req_cmd == CMD_DEQ;
			end
			ST_RUN: begin
				cmd.issue = stat.issue_ok;
			end
			default: req_stall = 1'b1;
		endcase
	end

endmodule

// File: rtl/core/opr_dp.sv
// Datapath for the overwriting packet ring queue.
// Holds the byte store, slot sizes, ring pointers, read stage and output register.
// Depends on opr_pkg.
`timescale 1ns / 1ps

module opr_dp import opr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  req_item_t req,
	input  ctrl_cmd_t cmd,
	output dp_stat_t  stat,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(QUEUE_SLOTS - 1);
	localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(PACKET_BYTES);

	logic [7:0]        mem [STORE_DEPTH];
	logic [CNT_W-1:0]  sizes_q [QUEUE_SLOTS];
	logic [SLOT_W-1:0] wr_slot_q;
	logic [SLOT_W-1:0] rd_slot_q;
	logic              lapped_q;
	logic [CNT_W-1:0]  fill_q;

	// Current dequeue
	logic [SLOT_W-1:0] cur_slot_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  last_idx_q;
	logic [CNT_W-1:0]  deq_size_q;
	logic              deq_empty_q;
	logic              deq_zero_q;

	// Read stage
	logic              valid_s1;
	logic [7:0]        rdata_s1;
	logic [CNT_W-1:0]  size_s1;
	logic              empty_s1;
	logic              zero_s1;
	logic              last_s1;
	logic              s1_move;

	logic              out_valid_q;
	rsp_item_t         out_q;

	logic              fill_room;
	logic [CNT_W-1:0]  fill_next;
	logic [ADDR_W-1:0] waddr;
	logic [ADDR_W-1:0] raddr;
	logic              is_empty;
	logic [SLOT_W-1:0] eff_slot;
	logic [CNT_W-1:0]  eff_size;

	// Enqueue address and fill count
	assign fill_room = fill_q < FULL_CNT;
	assign fill_next = fill_room ? fill_q + CNT_W'(1) : fill_q;
	assign waddr     = ADDR_W'(wr_slot_q) * ADDR_W'(PACKET_BYTES) + ADDR_W'(fill_q);
	assign raddr     = ADDR_W'(cur_slot_q) * ADDR_W'(PACKET_BYTES) + ADDR_W'(idx_q);

	// Dequeue decision: skip overwritten packets after a lap
	assign is_empty = !lapped_q && rd_slot_q == wr_slot_q;
	assign eff_slot = (lapped_q && rd_slot_q < wr_slot_q) ? wr_slot_q : rd_slot_q;
	assign eff_size = sizes_q[eff_slot];

	// Read stage moves into the output register when that register is empty or its result is taken
	assign s1_move         = valid_s1 && (!out_valid_q || !rsp_stall);
	assign stat.issue_ok   = !valid_s1 || s1_move;
	assign stat.last_issue = idx_q == last_idx_q;

	// Byte store: write on enqueue while the slot has room, registered read on issue
	always_ff @(posedge clk) begin
		if (cmd.enq_write && fill_room) begin
			mem[waddr] <= req.data_byte;
		end
		if (cmd.issue) begin
			rdata_s1 <= mem[raddr];
		end
	end

	// Ring pointers, sizes and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_SLOTS; i++) begin
				sizes_q[i] <= '0;
			end
			wr_slot_q <= '0;
			rd_slot_q <= '0;
			lapped_q  <= 1'b0;
			fill_q    <= '0;
		end else begin
			if (cmd.enq_write) begin
				if (req.last_byte) begin
					sizes_q[wr_slot_q] <= fill_next;
					fill_q             <= '0;
					if (wr_slot_q == LAST_SLOT) begin
						wr_slot_q <= '0;
						lapped_q  <= 1'b1;
					end else begin
						wr_slot_q <= wr_slot_q + SLOT_W'(1);
					end
				end else begin
					fill_q <= fill_next;
				end
			end else if (cmd.deq_start && !is_empty) begin
				if (eff_slot == LAST_SLOT) begin
					rd_slot_q <= '0;
					lapped_q  <= 1'b0;
				end else begin
					rd_slot_q <= eff_slot + SLOT_W'(1);
				end
			end
		end
	end

	// Latch the dequeue parameters and step the byte index
	always_ff @(posedge clk) begin
		if (cmd.deq_start) begin
			cur_slot_q  <= eff_slot;
			idx_q       <= '0;
			deq_empty_q <= is_empty;
			deq_size_q  <= is_empty ? '0 : eff_size;
			deq_zero_q  <= is_empty || eff_size == '0;
			last_idx_q  <= (is_empty || eff_size == '0) ? '0 : eff_size - CNT_W'(1);
		end else if (cmd.issue) begin
			idx_q <= idx_q + CNT_W'(1);
		end
	end

	// Read stage flags
	always_ff @(posedge clk) begin
		if (cmd.issue) begin
			size_s1  <= deq_size_q;
			empty_s1 <= deq_empty_q;
			zero_s1  <= deq_zero_q;
			last_s1  <= stat.last_issue;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (cmd.issue) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	// Output register: load from the read stage, drop when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_move) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_q.out_byte    <= zero_s1 ? 8'd0 : rdata_s1;
			out_q.packet_size <= SIZE_W'(size_s1);
			out_q.queue_empty <= empty_s1;
			out_q.last_out    <= last_s1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef SYNTH
	// A read never lands on an occupied read stage that cannot move
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> (!valid_s1 || s1_move))
		else $error("read stage overrun");

	// Store writes and byte reads never overlap
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.enq_write && (cmd.issue || cmd.deq_start)))
		else $error("enqueue overlaps dequeue");

	// Fill count stays within one slot
	a_fill: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FULL_CNT)
		else $error("fill count out of range");

	// An empty result is a single, sizeless, final item
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.queue_empty) |->
			(out_q.last_out && out_q.packet_size == '0 && out_q.out_byte == 8'd0))
		else $error("malformed empty result");
`endif

endmodule

// File: rtl/core/overwrite_packet_ring_queue.sv
// Top level of the overwriting packet ring queue.
// Joins the controller and the datapath; depends on opr_pkg, opr_ctrl and opr_dp.
//
// channel   valid      stall      payload
// request   req_valid  req_stall  req (req_item_t: cmd, data_byte, last_byte)
// response  rsp_valid  rsp_stall  rsp (rsp_item_t: out_byte, packet_size, queue_empty, last_out)
//
// An enqueue item is taken while the controller is idle and writes the byte store as it is accepted.
// A dequeue item of n results (n = packet size, or 1 when empty or size zero) holds
// req_stall high while the controller issues its n store reads, one per cycle unless stalled.
// rsp_valid for the first result follows the accepted dequeue through the controller's run
// state, the registered store read and the output register.
// Response stalls back up through the read stage and pause the reads.
// Reset is asynchronous; no clearing pass, the byte store is left as it is.
`timescale 1ns / 1ps

module overwrite_packet_ring_queue import opr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp
);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	opr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_cmd   (req.cmd),
		.req_stall (req_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	opr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

// File: tb/sv/overwrite_packet_ring_queue_test.sv
// Self-checking testbench for the overwriting packet ring queue.
// Needs opr_pkg and the overwrite_packet_ring_queue RTL; reads no files.
// Checks every result against an in-bench ring predictor.
`timescale 1ns / 1ps

module overwrite_packet_ring_queue_test;
	import opr_pkg::*;

	localparam int CLK_HALF      = 6;
	localparam int HOLD_CYCLES   = 300;
	localparam int DRAIN_CYCLES  = 8;
	localparam int PHASE_ITEMS   = 140;
	localparam int MAX_PRINTS    = 40;

	logic      clk       = 1'b0;
	logic      arst_n    = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req       = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp;

	req_item_t pending_reqs [$];
	rsp_item_t expected_rsps [$];
	int        mismatch_count = 0;
	int        send_idle_pct  = 0;
	int        recv_idle_pct  = 0;
	int        phase_no       = 0;
	logic      hold_rsp       = 1'b0;

	// Predicted ring contents and pointers
	logic [7:0]        ring_bytes [STORE_DEPTH];
	bit   [SIZE_W-1:0] ring_sizes [QUEUE_SLOTS];
	bit   [SLOT_W-1:0] wr_slot    = '0;
	bit   [SLOT_W-1:0] rd_slot    = '0;
	bit                lapped     = 1'b0;
	bit   [CNT_W-1:0]  fill_cnt   = '0;

	overwrite_packet_ring_queue uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	// Hold reset at the start, then release it between edges
	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
	end

	task automatic note_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS)
			$display("%0t ns mismatch: %s", $realtime, msg);
	endtask

	task automatic push_result(input logic [7:0] b, input int sz, input logic empty,
			input logic last);
		rsp_item_t r;
		r.out_byte    = b;
		r.packet_size = SIZE_W'(sz);
		r.queue_empty = empty;
		r.last_out    = last;
		expected_rsps.push_back(r);
	endtask

	// Advance the predicted ring by one accepted item
	task automatic apply_to_ring(input req_item_t it);
		int sz;
		int base;
		if (it.cmd == CMD_ENQ) begin
			if (fill_cnt < PACKET_BYTES) begin
				ring_bytes[int'(wr_slot) * PACKET_BYTES + int'(fill_cnt)] = it.data_byte;
				fill_cnt++;
			end
			if (it.last_byte) begin
				ring_sizes[wr_slot] = SIZE_W'(fill_cnt);
				fill_cnt = '0;
				if (wr_slot == SLOT_W'(QUEUE_SLOTS - 1)) begin
					wr_slot = '0;
					lapped  = 1'b1;
				end else begin
					wr_slot++;
				end
			end
		end else if (!lapped && rd_slot == wr_slot) begin
			push_result(8'd0, 0, 1'b1, 1'b1);
		end else begin
			// skip packets that were overwritten since the last lap
			if (lapped && rd_slot < wr_slot)
				rd_slot = wr_slot;
			sz = int'(ring_sizes[rd_slot]);
			if (sz > PACKET_BYTES)
				sz = PACKET_BYTES;
			base = int'(rd_slot) * PACKET_BYTES;
			if (sz == 0) begin
				push_result(8'd0, 0, 1'b0, 1'b1);
			end else begin
				for (int i = 0; i < sz; i++)
					push_result(ring_bytes[base + i], sz, 1'b0, i == sz - 1);
			end
			if (rd_slot == SLOT_W'(QUEUE_SLOTS - 1)) begin
				rd_slot = '0;
				lapped  = 1'b0;
			end else begin
				rd_slot++;
			end
		end
	endtask

	task automatic check_rsp(input rsp_item_t got);
		rsp_item_t want;
		if (expected_rsps.size() == 0) begin
			note_mismatch($sformatf("unexpected result, byte %02h size %0d",
				got.out_byte, got.packet_size));
		end else begin
			want = expected_rsps.pop_front();
			if (got.out_byte !== want.out_byte)
				note_mismatch($sformatf("out_byte %02h, want %02h",
					got.out_byte, want.out_byte));
			if (got.packet_size !== want.packet_size)
				note_mismatch($sformatf("packet_size %0d, want %0d",
					got.packet_size, want.packet_size));
			if (got.queue_empty !== want.queue_empty)
				note_mismatch($sformatf("queue_empty %b, want %b",
					got.queue_empty, want.queue_empty));
			if (got.last_out !== want.last_out)
				note_mismatch($sformatf("last_out %b, want %b",
					got.last_out, want.last_out));
		end
	endtask

	// Request driver: present queued items, hold each until accepted
	always @(posedge clk) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall)
				apply_to_ring(req);
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req       <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: check accepted results, drive random stalls
	always @(posedge clk) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			if (rsp_valid && !rsp_stall)
				check_rsp(rsp);
			rsp_stall <= hold_rsp || ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	// Back-pressure burst: stall results long enough for requests to back up
	initial begin
		wait (phase_no == 3);
		@(posedge clk);
		hold_rsp <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rsp <= 1'b0;
	end

	initial begin
		#3_000_000;
		$display("[overwrite_packet_ring_queue] ERROR");
		$finish;
	end

	task automatic push_enq(input logic [7:0] b, input logic last);
		req_item_t it;
		it.cmd       = CMD_ENQ;
		it.data_byte = b;
		it.last_byte = last;
		pending_reqs.push_back(it);
	endtask

	task automatic push_deq();
		req_item_t it;
		it.cmd       = CMD_DEQ;
		it.data_byte = 8'($urandom_range(0, 255));
		it.last_byte = 1'($urandom_range(0, 1));
		pending_reqs.push_back(it);
	endtask

	task automatic push_packet(input int len);
		for (int i = 0; i < len; i++)
			push_enq(8'($urandom_range(0, 255)), i == len - 1);
	endtask

	// Mostly well-formed packets and dequeues; some partial packets with a
	// dequeue in the middle, a few oversized packets
	task automatic gen_random_traffic(input int n_items);
		int count;
		int pick;
		int len;
		int head;
		count = 0;
		while (count < n_items) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				len = $urandom_range(1, 6);
				push_packet(len);
				count += len;
			end else if (pick < 56) begin
				len = $urandom_range(7, PACKET_BYTES);
				push_packet(len);
				count += len;
			end else if (pick < 59) begin
				len = $urandom_range(PACKET_BYTES + 1, PACKET_BYTES + 8);
				push_packet(len);
				count += len;
			end else if (pick < 85) begin
				push_deq();
				count++;
			end else begin
				head = $urandom_range(1, 4);
				len  = $urandom_range(1, 3);
				for (int i = 0; i < head; i++)
					push_enq(8'($urandom_range(0, 255)), 1'b0);
				push_deq();
				push_packet(len);
				count += head + len + 1;
			end
		end
	endtask

	task automatic drain();
		while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
			@(negedge clk);
	endtask

	initial begin
		send_idle_pct = 35;
		recv_idle_pct = 73;
		phase_no      = 1;
		while (!arst_n)
			@(negedge clk);
		@(negedge clk);

		// Empty queue, extreme bytes, then fill all slots to lap the ring
		push_deq();
		push_enq(8'h00, 1'b1);
		push_enq(8'hFF, 1'b1);
		for (int i = 2; i < QUEUE_SLOTS; i++)
			push_enq(8'(i), 1'b1);
		// Overwrite the oldest slot, start a partial packet, then dequeue:
		// the read jumps past overwritten slots onto the partial one
		push_enq(8'h55, 1'b1);
		push_enq(8'hAA, 1'b0);
		push_deq();
		push_enq(8'h0F, 1'b1);
		push_deq();
		push_deq();
		push_deq();

		// Largest packet, and one whose last mark lands on a dropped byte
		push_packet(PACKET_BYTES);
		push_deq();
		push_packet(PACKET_BYTES + 1);
		push_deq();
		gen_random_traffic(PHASE_ITEMS - 2 * PACKET_BYTES);
		drain();

		send_idle_pct = 73;
		recv_idle_pct = 35;
		phase_no      = 2;
		gen_random_traffic(PHASE_ITEMS);
		drain();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		phase_no      = 3;
		gen_random_traffic(PHASE_ITEMS);
		drain();

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (expected_rsps.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", expected_rsps.size()));
		if (mismatch_count == 0)
			$display("[overwrite_packet_ring_queue] OK");
		else
			$display("[overwrite_packet_ring_queue] ERROR");
		$finish;
	end

endmodule
